>>> rtl/rgb_to_yuv420_converter_top_macros.svh
// Assertion macros shared by the checker of the RGB to YUV 4:2:0 converter.
`ifndef RGB_TO_YUV420_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_TOP_MACROS_SVH

// Checked at every rising edge of clk, switched off while rst is high.
`define R2Y_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define R2Y_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/r2y_pkg.sv
// Types and constants of the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps
package r2y_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [CFG_W-1:0] MIN_DIM      = 12'd2;
  localparam logic [CFG_W-1:0] MAX_HEIGHT   = 12'd2048;

  // Luma weights, all positive.
  localparam logic [14:0] Y_R = 15'd9796;
  localparam logic [14:0] Y_G = 15'd19235;
  localparam logic [14:0] Y_B = 15'd3736;

  // Chroma weights, signed.
  localparam logic signed [15:0] U_R = -16'sd4784;
  localparam logic signed [15:0] U_G = -16'sd9437;
  localparam logic signed [15:0] U_B = 16'sd14221;
  localparam logic signed [15:0] V_R = 16'sd20218;
  localparam logic signed [15:0] V_G = -16'sd16941;
  localparam logic signed [15:0] V_B = -16'sd3277;

  localparam int LUMA_SHIFT   = 15;
  localparam int CHROMA_SHIFT = 17;
  localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd32;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] cb_value;
    logic [PIX_W-1:0] cr_value;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] term_u;
    logic [PIX_W-1:0] term_v;
  } color_terms_t;

endpackage

>>> rtl/r2y_if.sv
// Valid/ready channel interfaces for pixels in and YUV results out.
`timescale 1ns / 1ps
interface r2y_pixel_if import r2y_pkg::*;;
  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface r2y_result_if import r2y_pkg::*;;
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rgb_to_yuv420_converter_top.sv
// RGB to YUV 4:2:0 converter: one RGB pixel in, one luma (and block chroma) result out.
//
// Usage: RGB pixels enter in raster order on the pixel channel (valid/ready).
// Every accepted request gives exactly one request on the result channel with
// the pixel's luma. On odd rows at odd columns the result also carries the Cb
// and Cr of the finished 2x2 block, flagged by chroma_valid. frame_end marks
// the last pixel of a frame. The frame geometry comes from image_width
// (index 0) and frame_height (index 1) on the configuration write port;
// write them only while no pixel is in flight.
// Each pixel passes the input register, then the result register, before its
// result is presented. One pixel is taken every cycle unless the receiver
// stalls; the rate is set by the single color matrix between those two
// registers.
// Chroma pair sums of even rows live in two line stores of MAX_WIDTH/2 bytes,
// read at accept time and written when the even-row pixel moves to the
// result register. The line stores are not cleared.
// Reset: counters return to the top left of a frame, geometry to 640x480 and
// both stages empty. When the receiver stalls, the result register holds and
// the input stage fills, after which pixel.ready drops.
`timescale 1ns / 1ps
module rgb_to_yuv420_converter_top import r2y_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  r2y_pixel_if.sink            pixel,
  r2y_result_if.source         result
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W = ($clog2(MAX_WIDTH) > ADDR_W + 1) ? $clog2(MAX_WIDTH) : ADDR_W + 1;
  localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam logic [CMP_W-1:0] MAX_WIDTH_C = CMP_W'(MAX_WIDTH);

  // Configuration registers.
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] frame_height;

  // Position of the next pixel.
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  // Input stage.
  logic              in_fire;
  logic              stage_valid;
  pixel_t            stage_pixel;
  logic              stage_odd_col;
  logic              stage_odd_row;
  logic              stage_last;
  logic [ADDR_W-1:0] stage_addr;
  logic              stage_adv;
  logic              stage_move;

  // Line stores and their registered read data.
  logic [PIX_W-1:0] line_u [LINE_DEPTH];
  logic [PIX_W-1:0] line_v [LINE_DEPTH];
  logic [PIX_W-1:0] rd_u;
  logic [PIX_W-1:0] rd_v;
  logic [ADDR_W-1:0] addr_in;
  logic              store_we;

  logic [PIX_W-1:0] pair_sum_u;
  logic [PIX_W-1:0] pair_sum_v;

  // Result register.
  logic    out_valid;
  result_t out_data;
  result_t result_next;

  color_terms_t terms;
  logic [PIX_W-1:0] pu;
  logic [PIX_W-1:0] pv;

  logic [CMP_W-1:0] w_raw;
  logic [CMP_W-1:0] w_clamp;
  logic [CMP_W-1:0] w_eff;
  logic [CFG_W-1:0] h_clamp;
  logic [CFG_W-1:0] h_eff;
  logic             last_col;
  logic             last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  // Geometry is clamped to its range and always rounded down to even.
  always_comb begin
    w_raw = CMP_W'(image_width);
    if (w_raw < CMP_W'(MIN_DIM)) begin
      w_clamp = CMP_W'(MIN_DIM);
    end else if (w_raw > MAX_WIDTH_C) begin
      w_clamp = MAX_WIDTH_C;
    end else begin
      w_clamp = w_raw;
    end
    w_eff = {w_clamp[CMP_W-1:1], 1'b0};

    if (frame_height < MIN_DIM) begin
      h_clamp = MIN_DIM;
    end else if (frame_height > MAX_HEIGHT) begin
      h_clamp = MAX_HEIGHT;
    end else begin
      h_clamp = frame_height;
    end
    h_eff = {h_clamp[CFG_W-1:1], 1'b0};
  end

  assign last_col = (CMP_W'(column_count) + CMP_W'(1)) >= w_eff;
  assign last_row = (CFG_W'(row_count) + CFG_W'(1)) >= h_eff;

  assign stage_adv   = !out_valid || result.ready;
  assign pixel.ready = !stage_valid || stage_adv;
  assign in_fire     = pixel.valid && pixel.ready;
  assign stage_move  = stage_valid && stage_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (pixel.ready) begin
      stage_valid <= pixel.valid;
    end
  end

  assign addr_in = column_count[ADDR_W:1];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_pixel   <= pixel.data;
      stage_odd_col <= column_count[0];
      stage_odd_row <= row_count[0];
      stage_last    <= last_col && last_row;
      stage_addr    <= addr_in;
    end
  end

  r2y_color_matrix u_matrix (
    .pixel (stage_pixel),
    .terms (terms)
  );

  assign pu = pair_sum_u + terms.term_u;
  assign pv = pair_sum_v + terms.term_v;
  assign store_we = stage_move && stage_odd_col && !stage_odd_row;

  // The read for a block is issued when its odd-row, odd-column pixel is
  // accepted; the matching even-row write has left the input stage by then.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_u <= line_u[addr_in];
      rd_v <= line_v[addr_in];
    end
    if (store_we) begin
      line_u[stage_addr] <= pu;
      line_v[stage_addr] <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_sum_u <= '0;
      pair_sum_v <= '0;
    end else if (stage_move && !stage_odd_col) begin
      pair_sum_u <= terms.term_u;
      pair_sum_v <= terms.term_v;
    end
  end

  always_comb begin
    result_next.luma         = terms.luma;
    result_next.chroma_valid = stage_odd_col && stage_odd_row;
    result_next.frame_end    = stage_last;
    if (stage_odd_col && stage_odd_row) begin
      result_next.cb_value = rd_u + pu;
      result_next.cr_value = rd_v + pv;
    end else begin
      result_next.cb_value = '0;
      result_next.cr_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      out_data <= result_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

>>> rtl/r2y_color_matrix.sv
// Color matrix: luma and the per-pixel chroma terms of one RGB pixel.
`timescale 1ns / 1ps
module r2y_color_matrix import r2y_pkg::*; (
  input  pixel_t       pixel,
  output color_terms_t terms
);

  logic [22:0]        y_sum;
  logic signed [8:0]  r_s;
  logic signed [8:0]  g_s;
  logic signed [8:0]  b_s;
  logic signed [24:0] u_sum;
  logic signed [24:0] v_sum;
  logic signed [24:0] u_q;
  logic signed [24:0] v_q;

  assign y_sum = 23'(Y_R) * 23'(pixel.red) + 23'(Y_G) * 23'(pixel.green)
               + 23'(Y_B) * 23'(pixel.blue);

  assign r_s = $signed({1'b0, pixel.red});
  assign g_s = $signed({1'b0, pixel.green});
  assign b_s = $signed({1'b0, pixel.blue});

  assign u_sum = 25'(U_R) * 25'(r_s) + 25'(U_G) * 25'(g_s) + 25'(U_B) * 25'(b_s);
  assign v_sum = 25'(V_R) * 25'(r_s) + 25'(V_G) * 25'(g_s) + 25'(V_B) * 25'(b_s);

  // The arithmetic shift rounds toward minus infinity; only the low byte matters.
  assign u_q = u_sum >>> CHROMA_SHIFT;
  assign v_q = v_sum >>> CHROMA_SHIFT;

  assign terms.luma   = y_sum[LUMA_SHIFT +: PIX_W];
  assign terms.term_u = u_q[PIX_W-1:0] + CHROMA_OFFSET;
  assign terms.term_v = v_q[PIX_W-1:0] + CHROMA_OFFSET;

endmodule

>>> rtl/r2y_checker.sv
// Port-level checker of the RGB to YUV 4:2:0 converter and its bind.
`timescale 1ns / 1ps
`include "rgb_to_yuv420_converter_top_macros.svh"
module r2y_checker import r2y_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  logic stalled;
  logic no_block;
  logic chroma_zero;

  assign stalled     = out_valid && !out_ready;
  assign no_block    = out_valid && !out_data.chroma_valid;
  assign chroma_zero = (out_data.cb_value == '0) && (out_data.cr_value == '0);

  // A request that waits on the receiver keeps its contents.
  `R2Y_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_data), "result changed while stalled")

  // Reset leaves no result pending.
  `R2Y_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

  // With the result register empty, the block must take a pixel.
  `R2Y_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with empty output")

  // Chroma fields read zero unless a block completes.
  `R2Y_ASSERT(a_chroma_zero, no_block |-> chroma_zero, "chroma nonzero without a block")

endmodule

bind rgb_to_yuv420_converter_top r2y_checker u_r2y_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
